// ----- rtl/core/ndoc_pkg.sv -----
// Package for the normal deviation outlier check: widths, types, acos table builder.
`default_nettype none

package ndoc_pkg;

    localparam int MAX_NEIGHBORS    = 256;
    localparam int ACOS_TABLE_DEPTH = 1024;

    localparam int ANGLE_MAX   = 2880;
    localparam int ANGLE_W     = 12;
    localparam int COMP_W      = 16;
    localparam int PROD_W      = 2 * COMP_W;
    localparam int DOT_W       = PROD_W + 1;
    localparam int OFF_W       = 30;
    localparam int IDX_W       = $clog2(ACOS_TABLE_DEPTH);
    localparam int SCALE_W     = OFF_W + IDX_W;
    localparam int CNT_W       = $clog2(MAX_NEIGHBORS + 1);
    localparam int SUM_W       = $clog2(MAX_NEIGHBORS * ANGLE_MAX + 1);
    localparam int NUM_W       = $clog2(MAX_NEIGHBORS * ANGLE_MAX + MAX_NEIGHBORS / 2 + 1);
    localparam int STEP_W      = $clog2(NUM_W);
    localparam int SDATA_W     = 6 * COMP_W;
    localparam int MDATA_W     = ((ANGLE_W + 7) / 8) * 8;
    localparam int QDEPTH      = 2;
    localparam int QPTR_W      = $clog2(QDEPTH);
    localparam int QFILL_W     = $clog2(QDEPTH + 1);

    localparam logic [ANGLE_W-1:0] THRESHOLD_RESET = ANGLE_W'(720);

    // Q2.28 unit and half step of the index scaling
    localparam logic signed [DOT_W-1:0] DOT_ONE  = DOT_W'(64'sd268435456);
    localparam logic [SCALE_W-1:0]      IDX_HALF = SCALE_W'(64'd268435456);

    typedef logic [ANGLE_W-1:0] acos_rom_t [ACOS_TABLE_DEPTH];

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [CNT_W-1:0] count;
    } run_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_OUT
    } back_state_t;

    localparam longint          Q30_ONE    = 64'sd1073741824;
    localparam longint unsigned PI_Q30     = 64'd3373259426;
    localparam longint unsigned HALF_TURN  = 64'd5760;
    localparam longint unsigned QUAD_ANGLE = 64'd2880;

    typedef longint unsigned taylor_div_t [10];
    localparam taylor_div_t TAYLOR_DIV = '{
        64'd2, 64'd12, 64'd30, 64'd56, 64'd90,
        64'd132, 64'd182, 64'd240, 64'd306, 64'd380
    };

    // cosine of h/32 degrees, Q30, Taylor series to x^20 on the folded angle
    function automatic longint cos_q30(input longint unsigned h_in);
        longint unsigned h;
        logic            neg;
        longint unsigned rad;
        longint unsigned x2;
        longint unsigned term;
        longint          acc;
        h   = h_in;
        neg = 1'b0;
        if (h > QUAD_ANGLE)
        begin
            h   = HALF_TURN - h;
            neg = 1'b1;
        end
        rad  = (h * PI_Q30 + QUAD_ANGLE) / HALF_TURN;
        x2   = (rad * rad) >> 30;
        term = longint'(Q30_ONE);
        acc  = Q30_ONE;
        for (int k = 0; k < 10; k++)
        begin
            term = ((term * x2) >> 30) / TAYLOR_DIV[k];
            if ((k % 2) == 0)
                acc = acc - longint'(term);
            else
                acc = acc + longint'(term);
        end
        return neg ? -acc : acc;
    endfunction

    // smallest angle a in 0..2880 with cos((2a+1)/32 deg) <= x, per table slot
    function automatic acos_rom_t build_acos_rom();
        acos_rom_t       rom;
        longint          dm1;
        longint          rhs;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        dm1 = longint'(ACOS_TABLE_DEPTH - 1);
        for (int idx = 0; idx < ACOS_TABLE_DEPTH; idx++)
        begin
            rhs = (2 * longint'(idx) - dm1) * Q30_ONE;
            lo  = 0;
            hi  = QUAD_ANGLE;
            while (lo < hi)
            begin
                mid = (lo + hi) >> 1;
                if (cos_q30(2 * mid + 1) * dm1 <= rhs)
                    hi = mid;
                else
                    lo = mid + 1;
            end
            rom[idx] = lo[ANGLE_W-1:0];
        end
        return rom;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/ndoc_front.sv -----
// Front end: dot product, clamp, acos table lookup and per-point accumulation.
`default_nettype none

module ndoc_front (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [ndoc_pkg::SDATA_W-1:0] s_tdata,
    input  wire logic                        s_tuser,
    input  wire logic                        s_tlast,
    output logic                             q_push,
    output ndoc_pkg::run_t                   q_wdata,
    input  wire logic                        q_full
);
    import ndoc_pkg::*;

    localparam acos_rom_t ACOS_ROM = build_acos_rom();

    logic en;

    logic v1_reg, self1_reg, last1_reg;
    logic signed [PROD_W-1:0] px1_reg, py1_reg, pz1_reg;

    logic v2_reg, self2_reg, last2_reg;
    logic [OFF_W-1:0] off2_reg;

    logic v3_reg, self3_reg, last3_reg;
    logic [IDX_W-1:0] idx3_reg;

    logic v4_reg, self4_reg, last4_reg;
    logic [ANGLE_W-1:0] ang4_reg;

    logic [SUM_W-1:0] acc_sum_reg, acc_sum_next;
    logic [CNT_W-1:0] acc_cnt_reg, acc_cnt_next;

    logic signed [COMP_W-1:0] cx, cy, cz, nx, ny, nz;
    logic signed [DOT_W-1:0]  dot, dot_clamped, dot_off;
    logic [SCALE_W-1:0]       scaled;
    logic                     take;

    assign cx = s_tdata[0*COMP_W +: COMP_W];
    assign cy = s_tdata[1*COMP_W +: COMP_W];
    assign cz = s_tdata[2*COMP_W +: COMP_W];
    assign nx = s_tdata[3*COMP_W +: COMP_W];
    assign ny = s_tdata[4*COMP_W +: COMP_W];
    assign nz = s_tdata[5*COMP_W +: COMP_W];

    assign en       = !(v4_reg && last4_reg && q_full);
    assign s_tready = en;

    always_comb
    begin
        dot = DOT_W'(px1_reg) + DOT_W'(py1_reg) + DOT_W'(pz1_reg);
        priority if (dot > DOT_ONE)
            dot_clamped = DOT_ONE;
        else if (dot < -DOT_ONE)
            dot_clamped = -DOT_ONE;
        else
            dot_clamped = dot;
        dot_off = dot_clamped + DOT_ONE;
    end

    assign scaled = SCALE_W'(off2_reg) * SCALE_W'(ACOS_TABLE_DEPTH - 1) + IDX_HALF;

    assign take         = !self4_reg && (acc_cnt_reg < CNT_W'(MAX_NEIGHBORS));
    assign acc_sum_next = acc_sum_reg + (take ? SUM_W'(ang4_reg) : SUM_W'(0));
    assign acc_cnt_next = acc_cnt_reg + CNT_W'(take);

    assign q_push        = en && v4_reg && last4_reg;
    assign q_wdata.sum   = acc_sum_next;
    assign q_wdata.count = acc_cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            acc_sum_reg <= '0;
            acc_cnt_reg <= '0;
        end
        else if (en)
        begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            if (v4_reg)
            begin
                if (last4_reg)
                begin
                    acc_sum_reg <= '0;
                    acc_cnt_reg <= '0;
                end
                else
                begin
                    acc_sum_reg <= acc_sum_next;
                    acc_cnt_reg <= acc_cnt_next;
                end
            end
        end
    end

    // payload stages, table read registered
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px1_reg   <= cx * nx;
            py1_reg   <= cy * ny;
            pz1_reg   <= cz * nz;
            self1_reg <= s_tuser;
            last1_reg <= s_tlast;

            off2_reg  <= dot_off[OFF_W-1:0];
            self2_reg <= self1_reg;
            last2_reg <= last1_reg;

            idx3_reg  <= scaled[OFF_W-1 +: IDX_W];
            self3_reg <= self2_reg;
            last3_reg <= last2_reg;

            ang4_reg  <= ACOS_ROM[idx3_reg];
            self4_reg <= self3_reg;
            last4_reg <= last3_reg;
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        acc_cnt_reg <= CNT_W'(MAX_NEIGHBORS))
        else $error("neighbor count above limit");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(acc_cnt_reg) && $stable(acc_sum_reg))
        else $error("accumulator moved during stall");

endmodule

`default_nettype wire

// ----- rtl/core/ndoc_queue.sv -----
// Two-entry queue of per-point totals between front and back.
`default_nettype none

module ndoc_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire ndoc_pkg::run_t wdata,
    output logic                full,
    input  wire logic           pop,
    output ndoc_pkg::run_t      rdata,
    output logic                nonempty
);
    import ndoc_pkg::*;

    run_t               mem_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QFILL_W-1:0] fill_reg, fill_next;

    assign full     = (fill_reg == QFILL_W'(QDEPTH));
    assign nonempty = (fill_reg != '0);
    assign rdata    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        fill_next = fill_reg;
        unique case ({push, pop})
            2'b10:   fill_next = fill_reg + 1'b1;
            2'b01:   fill_next = fill_reg - 1'b1;
            default: fill_next = fill_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wdata;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> nonempty)
        else $error("queue pop while empty");

endmodule

`default_nettype wire

// ----- rtl/core/ndoc_back.sv -----
// Back end: rounded mean by serial division, threshold compare, output register.
`default_nettype none

module ndoc_back (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         q_nonempty,
    input  wire ndoc_pkg::run_t               q_rdata,
    output logic                              q_pop,
    input  wire logic [ndoc_pkg::ANGLE_W-1:0] threshold,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic [ndoc_pkg::MDATA_W-1:0]      m_tdata,
    output logic                              m_tuser
);
    import ndoc_pkg::*;

    back_state_t state_reg, state_next;

    logic [NUM_W-1:0]   quo_reg;
    logic [CNT_W-1:0]   rem_reg;
    logic [CNT_W-1:0]   dvs_reg;
    logic               zero_reg;
    logic [STEP_W-1:0]  step_reg;
    logic [ANGLE_W-1:0] dev_reg;
    logic               outl_reg;

    logic               load, div_done;
    logic [CNT_W:0]     rem_sh;
    logic               ge;
    logic [NUM_W-1:0]   quo_next;
    logic [CNT_W-1:0]   rem_next;
    logic [ANGLE_W-1:0] dev_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (q_nonempty) state_next = ST_DIV;
            ST_DIV:  if (step_reg == STEP_W'(NUM_W - 1)) state_next = ST_OUT;
            ST_OUT:  if (m_tready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        load     = 1'b0;
        div_done = 1'b0;
        m_tvalid = 1'b0;
        unique case (state_reg)
            ST_IDLE: load = q_nonempty;
            ST_DIV:  div_done = (step_reg == STEP_W'(NUM_W - 1));
            ST_OUT:  m_tvalid = 1'b1;
            default: ;
        endcase
    end

    assign q_pop = load;

    // one restoring step per cycle
    always_comb
    begin
        rem_sh   = {rem_reg, quo_reg[NUM_W-1]};
        ge       = (rem_sh >= {1'b0, dvs_reg});
        rem_next = ge ? CNT_W'(rem_sh - {1'b0, dvs_reg}) : rem_sh[CNT_W-1:0];
        quo_next = {quo_reg[NUM_W-2:0], ge};
        dev_next = zero_reg ? '0 : quo_next[ANGLE_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            quo_reg  <= NUM_W'(q_rdata.sum) + NUM_W'(q_rdata.count >> 1);
            rem_reg  <= '0;
            dvs_reg  <= q_rdata.count;
            zero_reg <= (q_rdata.count == '0);
            step_reg <= '0;
        end
        else if (state_reg == ST_DIV)
        begin
            quo_reg  <= quo_next;
            rem_reg  <= rem_next;
            step_reg <= step_reg + 1'b1;
        end
        if (div_done)
        begin
            dev_reg  <= dev_next;
            outl_reg <= (dev_next > threshold);
        end
    end

    assign m_tdata = MDATA_W'(dev_reg);
    assign m_tuser = outl_reg;

    a_zero_mean: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT) && zero_reg |-> (dev_reg == '0) && !outl_reg)
        else $error("empty run produced nonzero result");

    a_pop_once: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> (state_reg == ST_DIV) && !q_pop)
        else $error("back end popped outside idle");

endmodule

`default_nettype wire

// ----- rtl/core/normal_deviation_outlier_check.sv -----
// Top level of the normal deviation outlier check: threshold register and core wiring.
//
// Input stream: one request per neighbor of a point. s_tdata carries the
// point normal and the neighbor normal, s_tuser marks the point itself (not
// counted) and s_tlast closes the point's run. Neighbor requests are taken
// one per clock while s_tready is high; each passes the front stages in order
// (three multipliers, clamp, index scaling, registered acos table read, accumulate)
// and the last request of a run pushes the run total into the queue.
// Output stream: one request per run, m_tdata = rounded mean angle (Q8.4),
// m_tuser = outlier flag. The back end divides one bit per cycle and takes
// a new run only after the output accepts the last result; a two-entry
// queue holds finished runs meanwhile. If runs arrive faster than the back
// end finishes them, the queue fills and s_tready drops until the back end
// catches up. A stalled output holds its result and in turn stalls the back
// end, then the queue, then the front.
// Reset clears the pipe, the accumulators and the queue, and loads the
// threshold with 45 degrees. Write the threshold only while idle.
`default_nettype none

module normal_deviation_outlier_check (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // center_x, center_y, center_z, neighbor_x, neighbor_y, neighbor_z
    input  wire logic [95:0] s_tdata,
    // is_self
    input  wire logic        s_tuser,
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // deviation_deg, zero padding
    output logic [15:0]      m_tdata,
    // is_outlier
    output logic             m_tuser,
    input  wire logic        cfg_we,
    input  wire logic [11:0] cfg_wdata
);
    import ndoc_pkg::*;

    logic [ANGLE_W-1:0] threshold_reg;

    logic q_push, q_full, q_pop, q_nonempty;
    run_t q_wdata, q_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            threshold_reg <= THRESHOLD_RESET;
        else if (cfg_we)
            threshold_reg <= cfg_wdata;
    end

    ndoc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .q_push   (q_push),
        .q_wdata  (q_wdata),
        .q_full   (q_full)
    );

    ndoc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .wdata    (q_wdata),
        .full     (q_full),
        .pop      (q_pop),
        .rdata    (q_rdata),
        .nonempty (q_nonempty)
    );

    ndoc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_nonempty (q_nonempty),
        .q_rdata    (q_rdata),
        .q_pop      (q_pop),
        .threshold  (threshold_reg),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule

`default_nettype wire

// ----- tb/sv/deviation_checker.sv -----
// Checker for the normal deviation outlier check: predicts mean angle and outlier flag per run.
`default_nettype none

module deviation_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [95:0] s_tdata,
    input  wire logic        s_tuser,
    input  wire logic        s_tlast,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [15:0] m_tdata,
    input  wire logic        m_tuser,
    input  wire logic        cfg_we,
    input  wire logic [11:0] cfg_wdata,
    output int               error_count,
    output int               outstanding
);

    import ndoc_pkg::*;

    localparam longint          Q30_UNIT  = 64'sd1073741824;
    localparam longint unsigned PI_Q30    = 64'd3373259426;
    localparam longint          DOT_LIMIT = 64'sd268435456;

    typedef struct {
        logic [ANGLE_W-1:0] deviation;
        logic               outlier;
    } verdict_t;

    logic [ANGLE_W-1:0] acos_lut [ACOS_TABLE_DEPTH];
    verdict_t           expected_verdicts [$];
    int                 angle_sum;
    int                 neighbor_count;
    logic [ANGLE_W-1:0] threshold;
    int                 failures = 0;

    // cos of h/32 degrees in Q30, folded to the first quadrant
    function automatic longint cosine_q30(input longint unsigned h);
        longint unsigned folded;
        longint unsigned rad;
        longint unsigned x2;
        longint unsigned term;
        longint          acc;
        bit              flip;
        flip   = (h > 2880);
        folded = flip ? 64'd5760 - h : h;
        rad    = (folded * PI_Q30 + 64'd2880) / 64'd5760;
        x2     = (rad * rad) >> 30;
        term   = Q30_UNIT;
        acc    = Q30_UNIT;
        for (int k = 1; k <= 10; k++)
        begin
            term = ((term * x2) >> 30) / 64'((2 * k - 1) * (2 * k));
            if (k % 2 == 1)
                acc = acc - longint'(term);
            else
                acc = acc + longint'(term);
        end
        return flip ? -acc : acc;
    endfunction

    function automatic logic [ANGLE_W-1:0] angle_lookup(input logic [95:0] data);
        longint          dot;
        longint unsigned offset;
        longint unsigned idx;
        dot = longint'($signed(data[15:0]))  * longint'($signed(data[63:48]))
            + longint'($signed(data[31:16])) * longint'($signed(data[79:64]))
            + longint'($signed(data[47:32])) * longint'($signed(data[95:80]));
        if (dot > DOT_LIMIT)
            dot = DOT_LIMIT;
        if (dot < -DOT_LIMIT)
            dot = -DOT_LIMIT;
        offset = longint'(dot + DOT_LIMIT);
        idx = (offset * 64'(ACOS_TABLE_DEPTH - 1) + 64'd268435456) >> 29;
        if (idx > 64'(ACOS_TABLE_DEPTH - 1))
            idx = 64'(ACOS_TABLE_DEPTH - 1);
        return acos_lut[idx];
    endfunction

    initial
    begin : build_lut
        longint          dm1;
        longint          rhs;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        dm1 = ACOS_TABLE_DEPTH - 1;
        for (int i = 0; i < ACOS_TABLE_DEPTH; i++)
        begin
            rhs = (2 * longint'(i) - dm1) * Q30_UNIT;
            lo  = 0;
            hi  = 2880;
            while (lo < hi)
            begin
                mid = (lo + hi) >> 1;
                if (cosine_q30(2 * mid + 1) * dm1 <= rhs)
                    hi = mid;
                else
                    lo = mid + 1;
            end
            acos_lut[i] = lo[ANGLE_W-1:0];
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : monitor
        verdict_t want;
        int       mean;
        if (!rst_n)
        begin
            expected_verdicts.delete();
            angle_sum      = 0;
            neighbor_count = 0;
            threshold      = THRESHOLD_RESET;
            outstanding   <= 0;
            error_count   <= failures;
        end
        else
        begin
            if (cfg_we)
                threshold = cfg_wdata;

            // results leave long after their run closes, so drain before adding
            if (m_tvalid && m_tready)
            begin
                if (expected_verdicts.size() == 0)
                begin
                    $display("%0t: unexpected result: expected none, got deviation %0d outlier %0b",
                             $time, m_tdata, m_tuser);
                    failures++;
                end
                else
                begin
                    want = expected_verdicts.pop_front();
                    if (m_tdata !== 16'(want.deviation))
                    begin
                        $display("%0t: deviation mismatch: expected %0d, got %0d",
                                 $time, want.deviation, m_tdata);
                        failures++;
                    end
                    if (m_tuser !== want.outlier)
                    begin
                        $display("%0t: outlier flag mismatch: expected %0b, got %0b",
                                 $time, want.outlier, m_tuser);
                        failures++;
                    end
                end
            end

            if (s_tvalid && s_tready)
            begin
                if (!s_tuser && neighbor_count < MAX_NEIGHBORS)
                begin
                    angle_sum      = angle_sum + angle_lookup(s_tdata);
                    neighbor_count = neighbor_count + 1;
                end
                if (s_tlast)
                begin
                    mean = 0;
                    if (neighbor_count > 0)
                        mean = (angle_sum + neighbor_count / 2) / neighbor_count;
                    want.deviation = mean[ANGLE_W-1:0];
                    want.outlier   = (mean > int'(threshold));
                    expected_verdicts.push_back(want);
                    angle_sum      = 0;
                    neighbor_count = 0;
                end
            end

            outstanding <= expected_verdicts.size();
            error_count <= failures;
        end
    end

endmodule

`default_nettype wire

// ----- tb/sv/normal_deviation_outlier_check_test.sv -----
// Testbench top for the normal deviation outlier check: clock, reset, stimulus and verdict.
`default_nettype none

module normal_deviation_outlier_check_test;

    localparam int DRAIN_CYCLES   = 40;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PHASE_REQUESTS = 460;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [95:0] s_tdata   = '0;
    logic        s_tuser   = 1'b0;
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tuser;
    logic        cfg_we    = 1'b0;
    logic [11:0] cfg_wdata = '0;

    int error_count;
    int outstanding;
    int idle_pct      = 0;
    int stall_pct     = 0;
    int sent_requests = 0;
    int quiet_cycles  = 0;

    normal_deviation_outlier_check dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    deviation_checker checker_inst (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .error_count (error_count),
        .outstanding (outstanding)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= stall_pct);

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic logic [15:0] to_q14(input real v);
        return 16'($rtoi(v * 16384.0 + ((v >= 0.0) ? 0.5 : -0.5)));
    endfunction

    function automatic void random_dir(output real vx, output real vy, output real vz);
        real z;
        real phi;
        real r;
        z   = 2.0 * $urandom_range(1000000) / 1000000.0 - 1.0;
        phi = 6.283185307 * $urandom_range(1000000) / 1000000.0;
        r   = $sqrt(1.0 - z * z);
        vx  = r * $cos(phi);
        vy  = r * $sin(phi);
        vz  = z;
    endfunction

    task automatic send_request(input logic [2:0][15:0] c, input logic [2:0][15:0] n,
                                input logic self_flag, input logic last_flag);
        while ($urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {n, c};
        s_tuser  <= self_flag;
        s_tlast  <= last_flag;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sent_requests++;
    endtask

    // wait for an empty pipe, then load the threshold
    task automatic write_threshold(input logic [11:0] value);
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // one point: neighbors spread around the center normal, or random components throughout, a self item at most once
    task automatic send_run(input int length);
        real              cx, cy, cz, rx, ry, rz, nx, ny, nz, norm, spread;
        logic [2:0][15:0] c;
        logic [2:0][15:0] n;
        int               kind;
        int               self_at;
        random_dir(cx, cy, cz);
        c       = {to_q14(cz), to_q14(cy), to_q14(cx)};
        kind    = $urandom_range(9);
        spread  = (kind < 4) ? 0.15 : ((kind < 7) ? 0.6 : 3.0);
        self_at = ($urandom_range(3) == 0) ? -1 : $urandom_range(length - 1);
        for (int i = 0; i < length; i++)
        begin
            if (kind == 9)
            begin
                c = {16'($urandom), 16'($urandom), 16'($urandom)};
                n = {16'($urandom), 16'($urandom), 16'($urandom)};
            end
            else if (i == self_at)
                n = c;
            else
            begin
                random_dir(rx, ry, rz);
                nx   = cx + spread * rx;
                ny   = cy + spread * ry;
                nz   = cz + spread * rz;
                norm = $sqrt(nx * nx + ny * ny + nz * nz);
                if (norm < 1.0e-6)
                    n = {to_q14(rz), to_q14(ry), to_q14(rx)};
                else
                    n = {to_q14(nz / norm), to_q14(ny / norm), to_q14(nx / norm)};
            end
            send_request(c, n, (i == self_at), (i == length - 1));
        end
    endtask

    initial
    begin : stimulus
        logic [11:0] phase_threshold [4];
        int          phase_idle [4];
        int          phase_stall [4];
        int          phase_start;
        int          length;
        phase_threshold = '{12'd0, 12'd4095, 12'd1440, 12'($urandom_range(2880))};
        phase_idle      = '{0, 88, 0, 37};
        phase_stall     = '{0, 0, 88, 37};

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // identical, opposite and perpendicular normals
        send_request({16'sd0, 16'sd0, 16'sd16384}, {16'sd0, 16'sd0, 16'sd16384}, 1'b0, 1'b1);
        send_request({16'sd0, 16'sd0, 16'sd16384}, {16'sd0, 16'sd0, -16'sd16384}, 1'b0, 1'b1);
        send_request({16'sd0, 16'sd16384, 16'sd0}, {16'sd16384, 16'sd0, 16'sd0}, 1'b0, 1'b1);
        // only the point itself: no neighbors
        send_request({16'sd16384, 16'sd0, 16'sd0}, {16'sd16384, 16'sd0, 16'sd0}, 1'b1, 1'b1);
        // self item closing a run
        send_request({16'sd16384, 16'sd0, 16'sd0}, {-16'sd16384, 16'sd0, 16'sd0}, 1'b0, 1'b0);
        send_request({16'sd16384, 16'sd0, 16'sd0}, {16'sd0, 16'sd16384, 16'sd0}, 1'b0, 1'b0);
        send_request({16'sd16384, 16'sd0, 16'sd0}, {16'sd16384, 16'sd0, 16'sd0}, 1'b1, 1'b1);
        // out-of-range components hit both clamp limits
        send_request({16'h8000, 16'h8000, 16'h8000}, {16'h8000, 16'h8000, 16'h8000}, 1'b0, 1'b1);
        send_request({16'h7fff, 16'h7fff, 16'h7fff}, {16'h8000, 16'h8000, 16'h8000}, 1'b0, 1'b1);
        send_request({-16'sd16384, -16'sd16384, -16'sd16384},
                     {16'sd16384, 16'sd16384, 16'sd16384}, 1'b0, 1'b1);
        send_request({16'hffff, 16'h0001, 16'h7fff}, {16'h0001, 16'hffff, 16'h7fff}, 1'b0, 1'b1);
        // self item at the start of a run
        send_request({16'sd0, 16'sd16384, 16'sd0}, {16'sd0, 16'sd16384, 16'sd0}, 1'b1, 1'b0);
        send_request({16'sd0, 16'sd16384, 16'sd0}, {16'sd0, 16'sd0, 16'sd16384}, 1'b0, 1'b1);

        // mean equal to the threshold is not an outlier
        write_threshold(12'd2880);
        send_request({16'sd0, 16'sd0, 16'sd16384}, {16'sd0, 16'sd0, -16'sd16384}, 1'b0, 1'b1);
        send_request({16'sd0, 16'sd16384, 16'sd0}, {16'sd16384, 16'sd0, 16'sd0}, 1'b0, 1'b1);
        send_request({16'sd0, 16'sd0, 16'sd16384}, {16'sd0, 16'sd0, 16'sd16384}, 1'b1, 1'b1);

        for (int p = 0; p < 4; p++)
        begin
            write_threshold(phase_threshold[p]);
            idle_pct    = phase_idle[p];
            stall_pct   = phase_stall[p];
            phase_start = sent_requests;
            // count saturation
            if (p == 0 || p == 2)
                send_run(300);
            while (sent_requests - phase_start < PHASE_REQUESTS)
            begin
                if ($urandom_range(3) == 0)
                    length = $urandom_range(3, 1);
                else
                    length = $urandom_range(40, 1);
                send_run(length);
            end
        end

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire

// ----- files.f -----
rtl/core/ndoc_pkg.sv
rtl/core/ndoc_front.sv
rtl/core/ndoc_queue.sv
rtl/core/ndoc_back.sv
rtl/core/normal_deviation_outlier_check.sv
tb/sv/deviation_checker.sv
tb/sv/normal_deviation_outlier_check_test.sv
